@@ hdl/ssf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types, segment constants and digit helpers for the sensor reading
// seven-segment formatter.
// ----------------------------------------------------------------------------
package ssf_pkg;

    typedef logic [7:0] seg_t;

    // Display mode carried with each reading
    typedef enum logic [1:0] {
        FUNC_ERROR      = 2'd0,
        FUNC_TENTHS     = 2'd1,
        FUNC_HUMIDITY   = 2'd2,
        FUNC_SIXTEENTHS = 2'd3
    } func_t;

    // Result status
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TEMP_NEG  = 3'd1,
        ST_TEMP_HIGH = 3'd2,
        ST_HUM_HIGH  = 3'd3,
        ST_TOO_LOW   = 3'd4,
        ST_TOO_HIGH  = 3'd5
    } status_t;

    // Four segment bytes, left to right, plus status
    typedef struct packed {
        seg_t    first;
        seg_t    second;
        seg_t    third;
        seg_t    fourth;
        status_t status;
    } ssf_result_t;

    localparam seg_t SEG_R     = 8'h50;
    localparam seg_t SEG_H_LO  = 8'h74;
    localparam seg_t SEG_H_UP  = 8'h76;
    localparam seg_t SEG_E     = 8'h79;
    localparam seg_t SEG_BLANK = 8'h00;
    localparam seg_t SEG_MINUS = 8'h40;
    localparam seg_t SEG_POINT = 8'h80;

    localparam logic [7:0]  NOT_YET_RESET   = 8'd1;
    localparam logic [15:0] TENTHS_MAX      = 16'd999;
    // largest raw humidity whose percent is still at most 100
    localparam logic [15:0] HUMIDITY_MAX    = 16'd1009;
    localparam logic [11:0] NEG_INT_MAX     = 12'd55;
    localparam logic [11:0] POS_INT_MAX     = 12'd99;
    // ceil(2^16 / 10): exact quotient for dividends below 1024
    localparam logic [12:0] DIV10_RECIP     = 13'd6554;
    localparam int          DIV10_SHIFT     = 16;

    // Hex digit to segment pattern
    function automatic seg_t glyph(input logic [3:0] d);
        seg_t g;
        case (d)
            4'h0: g = 8'h3f;
            4'h1: g = 8'h06;
            4'h2: g = 8'h5b;
            4'h3: g = 8'h4f;
            4'h4: g = 8'h66;
            4'h5: g = 8'h6d;
            4'h6: g = 8'h7d;
            4'h7: g = 8'h07;
            4'h8: g = 8'h7f;
            4'h9: g = 8'h6f;
            4'ha: g = 8'h77;
            4'hb: g = 8'h7c;
            4'hc: g = 8'h39;
            4'hd: g = 8'h5e;
            4'he: g = 8'h79;
            4'hf: g = 8'h71;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // Sixteenths to tenths digit, rounded to nearest
    function automatic logic [3:0] tenth_of_sixteenth(input logic [3:0] f);
        logic [3:0] t;
        case (f)
            4'd0:  t = 4'd0;
            4'd1:  t = 4'd1;
            4'd2:  t = 4'd1;
            4'd3:  t = 4'd2;
            4'd4:  t = 4'd3;
            4'd5:  t = 4'd3;
            4'd6:  t = 4'd4;
            4'd7:  t = 4'd4;
            4'd8:  t = 4'd5;
            4'd9:  t = 4'd6;
            4'd10: t = 4'd6;
            4'd11: t = 4'd7;
            4'd12: t = 4'd8;
            4'd13: t = 4'd8;
            4'd14: t = 4'd9;
            4'd15: t = 4'd9;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

    // Tens digit of a value 0..99 by parallel threshold compares
    function automatic logic [3:0] tens_of(input logic [6:0] x);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (x >= 7'(10 * k)) begin
                t = 4'(k);
            end
        end
        return t;
    endfunction

    // Units digit given the value and its tens digit
    function automatic logic [3:0] units_of(input logic [6:0] x, input logic [3:0] t);
        logic [6:0] t10;
        t10 = {t, 3'b000} + {2'b00, t, 1'b0};
        return 4'(x - t10);
    endfunction

endpackage

@@ hdl/ssf_format.sv @@
// ----------------------------------------------------------------------------
// ssf_format
// Combinational formatting of one reading into four segment bytes and a
// status code.
// ----------------------------------------------------------------------------
module ssf_format
    import ssf_pkg::*;
(
    input  func_t       func,
    input  logic [15:0] value,
    input  logic [7:0]  not_yet_code,
    output ssf_result_t result
);

    logic [9:0]  div_in;
    logic [22:0] div_prod;
    logic [6:0]  quot;
    logic [9:0]  quot_x10;
    logic [3:0]  rem;
    logic [3:0]  quot_tens;
    logic [3:0]  quot_units;
    logic [6:0]  pct;
    logic [3:0]  pct_tens;
    logic [3:0]  pct_units;
    logic [15:0] mag;
    logic [11:0] integral;
    logic [3:0]  int_tens;
    logic [3:0]  int_units;
    logic        neg;
    seg_t        sign;
    seg_t        tenth;
    logic [7:0]  code;

    // Divide the low ten bits by ten; both modes that use it reject larger values
    assign div_in     = value[9:0];
    assign div_prod   = 23'(div_in) * 23'(DIV10_RECIP);
    assign quot       = div_prod[DIV10_SHIFT +: 7];
    assign quot_x10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem        = 4'(div_in - quot_x10);
    assign quot_tens  = tens_of(quot);
    assign quot_units = units_of(quot, quot_tens);

    // Humidity percent, full scale shown as 99
    assign pct        = (quot == 7'd100) ? 7'd99 : quot;
    assign pct_tens   = tens_of(pct);
    assign pct_units  = units_of(pct, pct_tens);

    // Sixteenths temperature magnitude and sign
    assign neg        = value[15];
    assign mag        = neg ? (~value + 16'd1) : value;
    assign integral   = mag[15:4];
    assign int_tens   = tens_of(integral[6:0]);
    assign int_units  = units_of(integral[6:0], int_tens);
    assign sign       = neg ? SEG_MINUS : SEG_BLANK;
    assign tenth      = glyph(tenth_of_sixteenth(mag[3:0]));

    assign code       = value[7:0];

    // Select the layout for the mode; out-of-range readings leave zeros
    always_comb begin
        result = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK, ST_OK};
        case (func)
            FUNC_ERROR: begin
                if (code == not_yet_code) begin
                    result = '{SEG_POINT, SEG_POINT, SEG_POINT, SEG_POINT, ST_OK};
                end else begin
                    result = '{SEG_E, SEG_R, glyph(code[7:4]), glyph(code[3:0]), ST_OK};
                end
            end
            FUNC_TENTHS: begin
                if (neg) begin
                    result.status = ST_TEMP_NEG;
                end else if (value > TENTHS_MAX) begin
                    result.status = ST_TEMP_HIGH;
                end else begin
                    result.first  = SEG_H_UP;
                    result.second = (quot < 7'd10) ? SEG_BLANK : glyph(quot_tens);
                    result.third  = glyph(quot_units) | SEG_POINT;
                    result.fourth = glyph(rem);
                end
            end
            FUNC_HUMIDITY: begin
                if (value > HUMIDITY_MAX) begin
                    result.status = ST_HUM_HIGH;
                end else begin
                    if (pct < 7'd10) begin
                        result.first  = glyph(pct[3:0]);
                        result.second = SEG_BLANK;
                    end else begin
                        result.first  = glyph(pct_tens);
                        result.second = glyph(pct_units);
                    end
                    result.third  = SEG_R;
                    result.fourth = SEG_H_LO;
                end
            end
            FUNC_SIXTEENTHS: begin
                if (neg && (integral > NEG_INT_MAX)) begin
                    result.status = ST_TOO_LOW;
                end else if (!neg && (integral > POS_INT_MAX)) begin
                    result.status = ST_TOO_HIGH;
                end else begin
                    if (integral < 12'd10) begin
                        result.first  = SEG_BLANK;
                        result.second = sign;
                        result.third  = glyph(integral[3:0]) | SEG_POINT;
                    end else begin
                        result.first  = sign;
                        result.second = glyph(int_tens);
                        result.third  = glyph(int_units) | SEG_POINT;
                    end
                    result.fourth = tenth;
                end
            end
            default: begin
                result = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK, ST_OK};
            end
        endcase
    end

endmodule

@@ hdl/sensor_reading_seven_segment_formatter.sv @@
// ----------------------------------------------------------------------------
// sensor_reading_seven_segment_formatter
// Turns sensor readings and error codes into four seven-segment bytes.
// ----------------------------------------------------------------------------
// Each transfer in carries a mode (s_tuser) and a 16-bit reading (s_tdata);
// each transfer out carries four segment bytes and a status. The block is a
// two-register pipeline: readings are captured in an input register, formatted
// by one pass of shallow logic (a divide by ten through a reciprocal multiply,
// digit compares and glyph lookup), and held in a result register. One reading
// is taken every cycle while the result side keeps up; a stalled result stops
// the pipeline only once both registers are full. The code shown as four dots
// is set through the cfg port (reset value 1); the user must write it only
// while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module sensor_reading_seven_segment_formatter
    import ssf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input readings
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [1:0]  s_tuser,   // [1:0] func
    // formatted results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] seg_first, [15:8] seg_second,
                                   // [23:16] seg_third, [31:24] seg_fourth
    output logic [2:0]  m_tuser,   // [2:0] status
    // configuration: not_yet_code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic        in_valid_reg;
    func_t       in_func_reg;
    logic [15:0] in_value_reg;
    logic        out_valid_reg;
    ssf_result_t out_reg;
    ssf_result_t out_next;
    logic [7:0]  not_yet_reg;
    logic        out_ready;
    logic        in_ready;

    // Advance when the next stage is empty or draining
    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;

    // Hold the configured not-yet code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            not_yet_reg <= NOT_YET_RESET;
        end else if (cfg_valid) begin
            not_yet_reg <= cfg_data;
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_func_reg  <= func_t'(s_tuser);
            in_value_reg <= s_tdata;
        end
    end

    ssf_format u_format (
        .func         (in_func_reg),
        .value        (in_value_reg),
        .not_yet_code (not_yet_reg),
        .result       (out_next)
    );

    // Load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.fourth, out_reg.third, out_reg.second, out_reg.first};
    assign m_tuser  = out_reg.status;

endmodule

@@ hdl/ssf_checker.sv @@
// ----------------------------------------------------------------------------
// ssf_checker
// Port-level checks for the sensor reading seven-segment formatter.
// ----------------------------------------------------------------------------
module ssf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Blank all digits on a failing status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != 3'd0) |-> (m_tdata == 32'd0))
        else $error("segments not blank on failing status");

    // Keep status within its defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= 3'd5))
        else $error("undefined status code");

    // Drop the result valid after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sensor_reading_seven_segment_formatter ssf_checker u_ssf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/tb_sensor_reading_seven_segment_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_reading_seven_segment_formatter
// Self-checking regression for the seven-segment sensor formatter.
// ----------------------------------------------------------------------------
// A directed table covers error codes, the dot pattern and the edges of every
// range. After that, random readings run in phases, with a new dot code
// before each phase. Each accepted reading is formatted by a local model, and
// the expected display is queued. Each result transfer is compared field by
// field against the oldest queued display. Both sides idle at random. One
// phase runs without idling. In one phase the result side holds off long
// enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_sensor_reading_seven_segment_formatter;
    import ssf_pkg::*;

    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 190;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int PLAN_ROWS     = 25;

    // one expected display: four digits left to right plus status
    typedef struct {
        seg_t    first, second, third, fourth;
        status_t status;
    } display_t;

    // directed stimulus row; known rows carry the display typed in
    typedef struct packed {
        logic        known;
        func_t       func;
        logic [15:0] value;
        seg_t        first, second, third, fourth;
        status_t     status;
    } plan_row_t;

    localparam seg_t DIGIT_SEGS [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

    // tenth for each sixteenth, rounded to nearest
    localparam int SIXTEENTH_TO_TENTH [16] = '{
        0, 1, 1, 2, 3, 3, 4, 4, 5, 6, 6, 7, 8, 8, 9, 9
    };

    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{1'b1, FUNC_ERROR,      16'h0001, 8'h80, 8'h80, 8'h80, 8'h80, ST_OK},
        '{1'b1, FUNC_ERROR,      16'hff00, 8'h79, 8'h50, 8'h3f, 8'h3f, ST_OK},
        '{1'b1, FUNC_ERROR,      16'h00ab, 8'h79, 8'h50, 8'h77, 8'h7c, ST_OK},
        '{1'b1, FUNC_ERROR,      16'hffff, 8'h79, 8'h50, 8'h71, 8'h71, ST_OK},
        '{1'b0, FUNC_ERROR,      16'h12cd, 8'h00, 8'h00, 8'h00, 8'h00, ST_OK},
        '{1'b0, FUNC_ERROR,      16'hab01, 8'h00, 8'h00, 8'h00, 8'h00, ST_OK},
        '{1'b1, FUNC_TENTHS,     16'd0,    8'h76, 8'h00, 8'hbf, 8'h3f, ST_OK},
        '{1'b0, FUNC_TENTHS,     16'd99,   8'h00, 8'h00, 8'h00, 8'h00, ST_OK},
        '{1'b0, FUNC_TENTHS,     16'd100,  8'h00, 8'h00, 8'h00, 8'h00, ST_OK},
        '{1'b1, FUNC_TENTHS,     16'd999,  8'h76, 8'h6f, 8'hef, 8'h6f, ST_OK},
        '{1'b1, FUNC_TENTHS,     16'd1000, 8'h00, 8'h00, 8'h00, 8'h00, ST_TEMP_HIGH},
        '{1'b1, FUNC_TENTHS,     16'h7fff, 8'h00, 8'h00, 8'h00, 8'h00, ST_TEMP_HIGH},
        '{1'b1, FUNC_TENTHS,     16'h8000, 8'h00, 8'h00, 8'h00, 8'h00, ST_TEMP_NEG},
        '{1'b1, FUNC_TENTHS,     16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, ST_TEMP_NEG},
        '{1'b1, FUNC_HUMIDITY,   16'd0,    8'h3f, 8'h00, 8'h50, 8'h74, ST_OK},
        '{1'b0, FUNC_HUMIDITY,   16'd100,  8'h00, 8'h00, 8'h00, 8'h00, ST_OK},
        '{1'b1, FUNC_HUMIDITY,   16'd1000, 8'h6f, 8'h6f, 8'h50, 8'h74, ST_OK},
        '{1'b1, FUNC_HUMIDITY,   16'd1009, 8'h6f, 8'h6f, 8'h50, 8'h74, ST_OK},
        '{1'b1, FUNC_HUMIDITY,   16'd1010, 8'h00, 8'h00, 8'h00, 8'h00, ST_HUM_HIGH},
        '{1'b1, FUNC_HUMIDITY,   16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, ST_HUM_HIGH},
        '{1'b1, FUNC_SIXTEENTHS, 16'h0000, 8'h00, 8'h00, 8'hbf, 8'h3f, ST_OK},
        '{1'b0, FUNC_SIXTEENTHS, 16'hfc81, 8'h00, 8'h00, 8'h00, 8'h00, ST_OK},
        '{1'b1, FUNC_SIXTEENTHS, 16'hfc80, 8'h00, 8'h00, 8'h00, 8'h00, ST_TOO_LOW},
        '{1'b1, FUNC_SIXTEENTHS, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00, ST_TOO_LOW},
        '{1'b1, FUNC_SIXTEENTHS, 16'h0640, 8'h00, 8'h00, 8'h00, 8'h00, ST_TOO_HIGH}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    display_t    pending_displays [$];
    logic [7:0]  dot_code    = NOT_YET_RESET;
    logic        idle_on     = 1'b1;
    logic        hold_req    = 1'b0;
    int          fail_count  = 0;

    sensor_reading_seven_segment_formatter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // End the run if the pipeline hangs
    initial begin
        #2_000_000;
        $display("sensor_reading_seven_segment_formatter regression: fail");
        $finish;
    end

    // Format one reading the way the display should show it
    function automatic display_t format_reading(func_t f, logic [15:0] v, logic [7:0] code);
        display_t d;
        int       whole, frac, pct, integral;
        logic     neg;
        logic [15:0] mag;
        d = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK, ST_OK};
        case (f)
            FUNC_ERROR: begin
                if (v[7:0] == code) begin
                    d = '{SEG_POINT, SEG_POINT, SEG_POINT, SEG_POINT, ST_OK};
                end else begin
                    d = '{SEG_E, SEG_R, DIGIT_SEGS[v[7:4]], DIGIT_SEGS[v[3:0]], ST_OK};
                end
            end
            FUNC_TENTHS: begin
                if (v[15]) begin
                    d.status = ST_TEMP_NEG;
                end else if (v > 16'd999) begin
                    d.status = ST_TEMP_HIGH;
                end else begin
                    whole = v / 10;
                    frac  = v % 10;
                    d.first  = SEG_H_UP;
                    d.second = (whole < 10) ? SEG_BLANK : DIGIT_SEGS[whole / 10];
                    d.third  = DIGIT_SEGS[whole % 10] | SEG_POINT;
                    d.fourth = DIGIT_SEGS[frac];
                end
            end
            FUNC_HUMIDITY: begin
                pct = v / 10;
                if (pct > 100) begin
                    d.status = ST_HUM_HIGH;
                end else begin
                    if (pct == 100) pct = 99;
                    if (pct < 10) begin
                        d.first  = DIGIT_SEGS[pct];
                        d.second = SEG_BLANK;
                    end else begin
                        d.first  = DIGIT_SEGS[pct / 10];
                        d.second = DIGIT_SEGS[pct % 10];
                    end
                    d.third  = SEG_R;
                    d.fourth = SEG_H_LO;
                end
            end
            default: begin
                neg      = v[15];
                mag      = neg ? 16'(~v + 16'd1) : v;
                integral = int'(mag >> 4);
                if (neg && integral > 55) begin
                    d.status = ST_TOO_LOW;
                end else if (!neg && integral > 99) begin
                    d.status = ST_TOO_HIGH;
                end else begin
                    d.fourth = DIGIT_SEGS[SIXTEENTH_TO_TENTH[mag[3:0]]];
                    if (integral < 10) begin
                        d.first  = SEG_BLANK;
                        d.second = neg ? SEG_MINUS : SEG_BLANK;
                    end else begin
                        d.first  = neg ? SEG_MINUS : SEG_BLANK;
                        d.second = DIGIT_SEGS[integral / 10];
                    end
                    d.third = DIGIT_SEGS[integral % 10] | SEG_POINT;
                end
            end
        endcase
        return d;
    endfunction

    // Random reading, mostly inside the range of its mode
    function automatic logic [15:0] pick_value(func_t f);
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return 16'($urandom);
        case (f)
            FUNC_ERROR:    return (roll < 55) ? {8'($urandom), dot_code} : 16'($urandom);
            FUNC_TENTHS:   return 16'($urandom_range(0, 1010));
            FUNC_HUMIDITY: return 16'($urandom_range(0, 1030));
            default: begin
                if (roll < 65) return 16'($urandom_range(0, 16'h06ff));
                return 16'(-$urandom_range(1, 16'h03ff));
            end
        endcase
    endfunction

    // Offer one reading and queue its display once the transfer is taken.
    // Called and returns at a falling edge.
    task automatic send_reading(func_t f, logic [15:0] v, display_t shown);
        while (idle_on && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        pending_displays.push_back(shown);
        @(negedge aclk);
    endtask

    // Stop offering and hold until every queued display has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_displays.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the dot code while the pipeline is empty
    task automatic write_dot_code(logic [7:0] code);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge aclk); while (!cfg_ready);
        dot_code = code;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Compare one field of a result transfer
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random stalls, or one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 10);
            end
        end
    end

    // Check each result transfer against the oldest queued display
    always @(posedge aclk) begin
        display_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_displays.size() == 0) begin
                $error("result with no reading pending: tdata %h tuser %h", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_displays.pop_front();
                check_field("seg_first",  want.first,  m_tdata[7:0]);
                check_field("seg_second", want.second, m_tdata[15:8]);
                check_field("seg_third",  want.third,  m_tdata[23:16]);
                check_field("seg_fourth", want.fourth, m_tdata[31:24]);
                check_field("status",     want.status, m_tuser);
            end
        end
    end

    // Stimulus sequence
    initial begin
        logic [7:0] phase_codes [PHASES];
        plan_row_t  row;
        display_t   shown;
        func_t      f;
        logic [15:0] v;
        phase_codes = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'($urandom)};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table at the reset dot code
        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = DIRECTED_PLAN[i];
            if (row.known) begin
                shown = '{row.first, row.second, row.third, row.fourth, row.status};
            end else begin
                shown = format_reading(row.func, row.value, dot_code);
            end
            send_reading(row.func, row.value, shown);
        end

        // random phases, each with its own dot code
        for (int p = 0; p < PHASES; p++) begin
            write_dot_code(phase_codes[p]);
            idle_on = (p != 1);
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                f = func_t'($urandom_range(3));
                v = pick_value(f);
                send_reading(f, v, format_reading(f, v, dot_code));
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_displays.size() == 0) begin
            $display("sensor_reading_seven_segment_formatter regression: pass");
        end else begin
            $display("sensor_reading_seven_segment_formatter regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ssf_pkg.sv
hdl/ssf_format.sv
hdl/sensor_reading_seven_segment_formatter.sv
hdl/ssf_checker.sv
tb/sv/tb_sensor_reading_seven_segment_formatter.sv
